[src/pbd_pkg.sv]
package pbd_pkg;

    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 8;
    localparam int PLANE_PIXELS_W = 25;
    localparam int CHANNEL_W      = 2;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    // register index taken from paddr[2]
    localparam logic REG_PLANE_PIXELS  = 1'b0;
    localparam logic REG_CHANNEL_INDEX = 1'b1;

    localparam logic [PLANE_PIXELS_W-1:0] PLANE_PIXELS_RESET = 25'd1;

    localparam logic [BYTE_W-1:0] HDR_SKIP = 8'h80;
    localparam logic [BYTE_W:0]   RUN_BASE = 9'd257;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_RUN     = 2'd2
    } pbd_mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } pbd_state_t;

    typedef struct packed {
        logic accept;
        logic run_step;
    } pbd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic run_start;
        logic run_end;
    } pbd_status_t;

endpackage

[src/pbd_if.sv]
interface pbd_byte_if;
    import pbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              start_plane;

    modport source (output valid, output data_byte, output start_plane, input ready);
    modport sink   (input valid, input data_byte, input start_plane, output ready);
endinterface

interface pbd_pixel_if #(
    parameter int PIXEL_INDEX_BITS = 24
);
    import pbd_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [PIXEL_INDEX_BITS-1:0] pixel_index;
    logic [BYTE_W-1:0]           byte_first;
    logic [BYTE_W-1:0]           byte_second;
    logic                        second_valid;
    logic [CHANNEL_W-1:0]        lane;
    logic                        run_last;
    logic                        plane_done;
    logic                        overrun;

    modport source (
        output valid, output pixel_index, output byte_first, output byte_second,
        output second_valid, output lane, output run_last, output plane_done,
        output overrun, input ready
    );
    modport sink (
        input valid, input pixel_index, input byte_first, input byte_second,
        input second_valid, input lane, input run_last, input plane_done,
        input overrun, output ready
    );
endinterface

[src/pbd_ctrl.sv]
module pbd_ctrl
    import pbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pbd_status_t status,
    output pbd_cmd_t    cmd
);

    pbd_state_t state_reg;
    pbd_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.out_free && status.run_start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free && status.run_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.run_step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = status.out_free;
                cmd.accept = in_valid && status.out_free;
            end
            ST_RUN:
            begin
                cmd.run_step = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/pbd_datapath.sv]
module pbd_datapath
    import pbd_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [BYTE_W-1:0]           data_byte,
    input  logic                        start_plane,
    input  logic [PLANE_PIXELS_W-1:0]   plane_pixels,
    input  logic [CHANNEL_W-1:0]        channel_index,
    input  pbd_cmd_t                    cmd,
    output pbd_status_t                 status,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [PIXEL_INDEX_BITS-1:0] pixel_index,
    output logic [BYTE_W-1:0]           byte_first,
    output logic [BYTE_W-1:0]           byte_second,
    output logic                        second_valid,
    output logic [CHANNEL_W-1:0]        lane,
    output logic                        run_last,
    output logic                        plane_done,
    output logic                        overrun
);

    localparam int IW = PIXEL_INDEX_BITS + 1;
    localparam int LW = (IW > PLANE_PIXELS_W) ? IW : PLANE_PIXELS_W;

    // decoder state
    pbd_mode_t           mode_reg, mode_next;
    logic [COUNT_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [COUNT_W-1:0]  run_length_reg, run_length_next;
    logic [IW-1:0]       next_pixel_reg, next_pixel_next;
    logic                finished_reg, finished_next;

    // run emission
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic                run_done_reg, run_done_next;
    logic                run_ovr_reg, run_ovr_next;
    logic [BYTE_W-1:0]   run_byte_reg, run_byte_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [PIXEL_INDEX_BITS-1:0] pix_reg, pix_next;
    logic [BYTE_W-1:0]           b0_reg, b0_next;
    logic [BYTE_W-1:0]           b1_reg, b1_next;
    logic                        sv_reg, sv_next;
    logic [CHANNEL_W-1:0]        lane_reg, lane_next;
    logic                        last_reg, last_next;
    logic                        done_reg, done_next;
    logic                        ovr_reg, ovr_next;

    pbd_mode_t          eff_mode;
    logic [COUNT_W-1:0] eff_bl;
    logic [COUNT_W-1:0] eff_rl;
    logic [IW-1:0]      eff_pix;
    logic               eff_fin;
    logic [LW-1:0]      pp_ext;
    logic [LW-1:0]      cap_ext;
    logic [IW-1:0]      limit;
    logic               past_end;
    logic [IW-1:0]      avail;
    logic [IW-1:0]      rl_ext;
    logic               run_ovr;
    logic [COUNT_W-1:0] run_n;
    logic               lit_done;
    logic [COUNT_W-1:0] bl_dec;
    logic [COUNT_W-1:0] step;
    logic               step_last;
    logic               load;

    always_comb
    begin
        // start_plane restarts the decoder before this byte is looked at
        eff_mode = start_plane ? MODE_HEADER : mode_reg;
        eff_bl   = start_plane ? '0 : bytes_left_reg;
        eff_rl   = start_plane ? '0 : run_length_reg;
        eff_pix  = start_plane ? '0 : next_pixel_reg;
        eff_fin  = start_plane ? 1'b0 : finished_reg;

        pp_ext  = LW'(plane_pixels);
        cap_ext = LW'(1) << PIXEL_INDEX_BITS;
        limit   = (pp_ext > cap_ext) ? cap_ext[IW-1:0] : pp_ext[IW-1:0];

        past_end = eff_fin || (eff_pix >= limit);
        avail    = limit - eff_pix;
        rl_ext   = IW'(eff_rl);
        run_ovr  = rl_ext > avail;
        run_n    = run_ovr ? avail[COUNT_W-1:0] : eff_rl;
        lit_done = (eff_pix + IW'(1)) >= limit;
        bl_dec   = (eff_bl != '0) ? (eff_bl - COUNT_W'(1)) : '0;

        step      = (rem_reg > COUNT_W'(1)) ? COUNT_W'(2) : COUNT_W'(1);
        step_last = rem_reg <= COUNT_W'(2);

        status.out_free  = !out_valid_reg || out_ready;
        status.run_start = !past_end && (eff_mode == MODE_RUN);
        status.run_end   = step_last;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        bytes_left_next = bytes_left_reg;
        run_length_next = run_length_reg;
        next_pixel_next = next_pixel_reg;
        finished_next   = finished_reg;
        rem_next        = rem_reg;
        run_done_next   = run_done_reg;
        run_ovr_next    = run_ovr_reg;
        run_byte_next   = run_byte_reg;

        load      = 1'b0;
        pix_next  = pix_reg;
        b0_next   = b0_reg;
        b1_next   = b1_reg;
        sv_next   = sv_reg;
        lane_next = lane_reg;
        last_next = last_reg;
        done_next = done_reg;
        ovr_next  = ovr_reg;

        if (cmd.accept)
        begin
            mode_next       = eff_mode;
            bytes_left_next = eff_bl;
            run_length_next = eff_rl;
            next_pixel_next = eff_pix;
            finished_next   = eff_fin;
            if (past_end)
            begin
                load      = 1'b1;
                pix_next  = '0;
                b0_next   = '0;
                b1_next   = '0;
                sv_next   = 1'b0;
                lane_next = channel_index;
                last_next = 1'b1;
                done_next = 1'b1;
                ovr_next  = 1'b1;
            end
            else
            begin
                case (eff_mode)
                    MODE_LITERAL:
                    begin
                        load            = 1'b1;
                        pix_next        = eff_pix[PIXEL_INDEX_BITS-1:0];
                        b0_next         = data_byte;
                        b1_next         = '0;
                        sv_next         = 1'b0;
                        lane_next       = channel_index;
                        last_next       = 1'b1;
                        done_next       = lit_done;
                        ovr_next        = 1'b0;
                        next_pixel_next = eff_pix + IW'(1);
                        finished_next   = lit_done;
                        bytes_left_next = bl_dec;
                        mode_next       = (bl_dec == '0) ? MODE_HEADER : MODE_LITERAL;
                    end
                    MODE_RUN:
                    begin
                        // hand the run to the emission loop
                        run_byte_next   = data_byte;
                        rem_next        = run_n;
                        run_done_next   = !(rl_ext < avail);
                        run_ovr_next    = run_ovr;
                        mode_next       = MODE_HEADER;
                        run_length_next = '0;
                    end
                    default:
                    begin
                        if (data_byte < HDR_SKIP)
                        begin
                            bytes_left_next = data_byte + COUNT_W'(1);
                            mode_next       = MODE_LITERAL;
                        end
                        else if (data_byte > HDR_SKIP)
                        begin
                            run_length_next = COUNT_W'(RUN_BASE - {1'b0, data_byte});
                            mode_next       = MODE_RUN;
                        end
                        else
                        begin
                            mode_next = MODE_HEADER;
                        end
                    end
                endcase
            end
        end
        else if (cmd.run_step)
        begin
            load            = 1'b1;
            pix_next        = next_pixel_reg[PIXEL_INDEX_BITS-1:0];
            b0_next         = run_byte_reg;
            b1_next         = (rem_reg > COUNT_W'(1)) ? run_byte_reg : '0;
            sv_next         = rem_reg > COUNT_W'(1);
            lane_next       = channel_index;
            last_next       = step_last;
            done_next       = step_last && run_done_reg;
            ovr_next        = step_last && run_ovr_reg;
            next_pixel_next = next_pixel_reg + IW'(step);
            rem_next        = rem_reg - step;
            if (step_last)
            begin
                finished_next = run_done_reg;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HEADER;
            bytes_left_reg <= '0;
            run_length_reg <= '0;
            next_pixel_reg <= '0;
            finished_reg   <= 1'b0;
            rem_reg        <= '0;
            run_done_reg   <= 1'b0;
            run_ovr_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            bytes_left_reg <= bytes_left_next;
            run_length_reg <= run_length_next;
            next_pixel_reg <= next_pixel_next;
            finished_reg   <= finished_next;
            rem_reg        <= rem_next;
            run_done_reg   <= run_done_next;
            run_ovr_reg    <= run_ovr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_byte_reg <= run_byte_next;
        pix_reg      <= pix_next;
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        sv_reg       <= sv_next;
        lane_reg     <= lane_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
        ovr_reg      <= ovr_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_index  = pix_reg;
    assign byte_first   = b0_reg;
    assign byte_second  = b1_reg;
    assign second_valid = sv_reg;
    assign lane         = lane_reg;
    assign run_last     = last_reg;
    assign plane_done   = done_reg;
    assign overrun      = ovr_reg;

endmodule

[src/packbits_plane_decoder.sv]
// PackBits decoder for one channel plane. Compressed bytes enter on the coded
// channel; every decoded byte leaves on the decoded channel with its pixel index
// and the configured byte lane. A header byte gives no result, and a literal
// byte gives one result. A run byte is taken and then holds the input while its
// n pixels leave two per result, n being the run length clipped at the plane
// end; all results pass through one output register, and any stall on the
// decoded channel also holds the input. Once the plane is full, each further
// byte without start_plane gives one result with overrun and plane_done set.
// plane_pixels (address 0) and channel_index (address 4) are to be written over
// APB by the user only while the block is idle; the block does not enforce it.
module packbits_plane_decoder
    import pbd_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    pbd_byte_if.sink              coded,
    pbd_pixel_if.source           decoded
);

    logic [PLANE_PIXELS_W-1:0] plane_pixels_reg, plane_pixels_next;
    logic [CHANNEL_W-1:0]      channel_index_reg, channel_index_next;
    logic                      cfg_write;

    pbd_cmd_t    cmd;
    pbd_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        plane_pixels_next  = plane_pixels_reg;
        channel_index_next = channel_index_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_PLANE_PIXELS:  plane_pixels_next  = pwdata[PLANE_PIXELS_W-1:0];
                REG_CHANNEL_INDEX: channel_index_next = pwdata[CHANNEL_W-1:0];
                default:           plane_pixels_next  = plane_pixels_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PLANE_PIXELS:  prdata = APB_DATA_W'(plane_pixels_reg);
            REG_CHANNEL_INDEX: prdata = APB_DATA_W'(channel_index_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_pixels_reg  <= PLANE_PIXELS_RESET;
            channel_index_reg <= '0;
        end
        else
        begin
            plane_pixels_reg  <= plane_pixels_next;
            channel_index_reg <= channel_index_next;
        end
    end

    pbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (coded.valid),
        .in_ready (coded.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pbd_datapath #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (coded.data_byte),
        .start_plane   (coded.start_plane),
        .plane_pixels  (plane_pixels_reg),
        .channel_index (channel_index_reg),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (decoded.ready),
        .out_valid     (decoded.valid),
        .pixel_index   (decoded.pixel_index),
        .byte_first    (decoded.byte_first),
        .byte_second   (decoded.byte_second),
        .second_valid  (decoded.second_valid),
        .lane          (decoded.lane),
        .run_last      (decoded.run_last),
        .plane_done    (decoded.plane_done),
        .overrun       (decoded.overrun)
    );

endmodule

[src/pbd_checker.sv]
module pbd_checker
    import pbd_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [PIXEL_INDEX_BITS-1:0] res_pixel_index,
    input logic [BYTE_W-1:0]           res_byte_second,
    input logic                        res_second_valid,
    input logic                        res_run_last,
    input logic                        res_plane_done,
    input logic                        res_overrun
);

    // a stalled result transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_pixel_index))
    else $error("stalled result changed");

    // input is taken only when the pending result leaves in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && res_valid |-> res_ready)
    else $error("input taken while result blocked");

    // overrun only ends a transaction group on a full plane
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_overrun |-> res_plane_done && res_run_last)
    else $error("overrun without plane_done and run_last");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_second_valid |-> res_byte_second == '0)
    else $error("byte_second set without second_valid");

endmodule

bind packbits_plane_decoder pbd_checker #(
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
) u_pbd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (coded.ready),
    .res_valid        (decoded.valid),
    .res_ready        (decoded.ready),
    .res_pixel_index  (decoded.pixel_index),
    .res_byte_second  (decoded.byte_second),
    .res_second_valid (decoded.second_valid),
    .res_run_last     (decoded.run_last),
    .res_plane_done   (decoded.plane_done),
    .res_overrun      (decoded.overrun)
);

[verif/pbd_decode_checker.sv]
`timescale 1ns / 100ps

module pbd_decode_checker
    import pbd_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    pbd_byte_if                   coded,
    pbd_pixel_if                  decoded,
    output int                    errors,
    output int                    pending
);

    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] PLANE_CAP   = 64'd1 << PIXEL_INDEX_BITS;

    typedef struct packed {
        logic [PIXEL_INDEX_BITS-1:0] pixel_index;
        logic [BYTE_W-1:0]           byte_first;
        logic [BYTE_W-1:0]           byte_second;
        logic                        second_valid;
        logic [CHANNEL_W-1:0]        lane;
        logic                        run_last;
        logic                        plane_done;
        logic                        overrun;
    } pixel_t;

    pixel_t                    expected_pixels[$];
    logic [PLANE_PIXELS_W-1:0] plane_size;
    logic [CHANNEL_W-1:0]      lane_sel;
    pbd_mode_t                 mode;
    logic [COUNT_W-1:0]        literals_left;
    logic [COUNT_W-1:0]        run_count;
    logic [63:0]               next_pixel;
    logic                      plane_full;
    int                        mismatches;

    function automatic string show(pixel_t p);
        return $sformatf("idx=%0d b0=%02h b1=%02h v1=%0b lane=%0d last=%0b done=%0b ovr=%0b",
                         p.pixel_index, p.byte_first, p.byte_second, p.second_valid,
                         p.lane, p.run_last, p.plane_done, p.overrun);
    endfunction

    function automatic void emit(logic [63:0] idx, logic [BYTE_W-1:0] b0,
                                 logic [BYTE_W-1:0] b1, logic v1, logic last,
                                 logic done, logic ovr);
        pixel_t p;
        p.pixel_index  = idx[PIXEL_INDEX_BITS-1:0];
        p.byte_first   = b0;
        p.byte_second  = v1 ? b1 : '0;
        p.second_valid = v1;
        p.lane         = lane_sel;
        p.run_last     = last;
        p.plane_done   = done;
        p.overrun      = ovr;
        expected_pixels.push_back(p);
    endfunction

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic restart);
        logic [63:0] limit;
        logic [63:0] avail;
        logic [63:0] n;
        logic [63:0] k;
        logic        ovr;
        logic        done;
        logic        last;
        if (restart)
        begin
            next_pixel    = '0;
            plane_full    = 1'b0;
            mode          = MODE_HEADER;
            literals_left = '0;
            run_count     = '0;
        end
        limit = ({39'd0, plane_size} > PLANE_CAP) ? PLANE_CAP : {39'd0, plane_size};

        // plane already complete: flag the byte and leave state alone
        if (plane_full || next_pixel >= limit)
        begin
            emit('0, '0, '0, 1'b0, 1'b1, 1'b1, 1'b1);
            return;
        end

        case (mode)
            MODE_LITERAL:
            begin
                emit(next_pixel, b, '0, 1'b0, 1'b1, next_pixel + 64'd1 >= limit, 1'b0);
                next_pixel = next_pixel + 64'd1;
                if (next_pixel >= limit)
                    plane_full = 1'b1;
                if (literals_left != 0)
                    literals_left = literals_left - 1'b1;
                if (literals_left == 0)
                    mode = MODE_HEADER;
            end
            MODE_RUN:
            begin
                // clip the run at the plane end, two pixels per result
                avail = limit - next_pixel;
                n     = ({56'd0, run_count} < avail) ? {56'd0, run_count} : avail;
                ovr   = {56'd0, run_count} > avail;
                done  = (n == avail);
                for (k = 0; k < n; k = k + 2)
                begin
                    last = (k + 2 >= n);
                    emit(next_pixel + k, b, b, k + 1 < n, last, last && done, last && ovr);
                end
                next_pixel = next_pixel + n;
                if (done)
                    plane_full = 1'b1;
                mode      = MODE_HEADER;
                run_count = '0;
            end
            default:
            begin
                if (b < HDR_SKIP)
                begin
                    literals_left = b + 1'b1;
                    mode          = MODE_LITERAL;
                end
                else if (b > HDR_SKIP)
                begin
                    run_count = COUNT_W'(RUN_BASE - {1'b0, b});
                    mode      = MODE_RUN;
                end
                else
                    mode = MODE_HEADER;
            end
        endcase
    endtask

    task automatic check_pixel();
        pixel_t got;
        pixel_t want;
        string  bad;
        got.pixel_index  = decoded.pixel_index;
        got.byte_first   = decoded.byte_first;
        got.byte_second  = decoded.byte_second;
        got.second_valid = decoded.second_valid;
        got.lane         = decoded.lane;
        got.run_last     = decoded.run_last;
        got.plane_done   = decoded.plane_done;
        got.overrun      = decoded.overrun;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected pixel transaction: %s", $realtime, show(got));
            return;
        end
        want = expected_pixels.pop_front();
        bad  = "";
        if (got.pixel_index !== want.pixel_index)   bad = {bad, " pixel_index"};
        if (got.byte_first !== want.byte_first)     bad = {bad, " byte_first"};
        if (got.byte_second !== want.byte_second)   bad = {bad, " byte_second"};
        if (got.second_valid !== want.second_valid) bad = {bad, " second_valid"};
        if (got.lane !== want.lane)                 bad = {bad, " lane"};
        if (got.run_last !== want.run_last)         bad = {bad, " run_last"};
        if (got.plane_done !== want.plane_done)     bad = {bad, " plane_done"};
        if (got.overrun !== want.overrun)           bad = {bad, " overrun"};
        if (bad != "")
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: pixel mismatch on%s\n  expected %s\n  actual   %s",
                         $realtime, bad, show(want), show(got));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            plane_size    = PLANE_PIXELS_RESET;
            lane_sel      = '0;
            mode          = MODE_HEADER;
            literals_left = '0;
            run_count     = '0;
            next_pixel    = '0;
            plane_full    = 1'b0;
            mismatches    = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_PLANE_PIXELS:  plane_size = pwdata[PLANE_PIXELS_W-1:0];
                    REG_CHANNEL_INDEX: lane_sel   = pwdata[CHANNEL_W-1:0];
                    default: ;
                endcase
            end
            if (coded.valid && coded.ready)
                decode_byte(coded.data_byte, coded.start_plane);
            if (decoded.valid && decoded.ready)
                check_pixel();
            errors  <= mismatches;
            pending <= expected_pixels.size();
        end
    end

endmodule

[verif/packbits_plane_decoder_tb.sv]
`timescale 1ns / 100ps

module packbits_plane_decoder_tb;
    import pbd_pkg::*;

    localparam int PIX_BITS      = 24;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 16;

    localparam logic [APB_ADDR_W-1:0] ADDR_PLANE   = {REG_PLANE_PIXELS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_CHANNEL = {REG_CHANNEL_INDEX, 2'b00};

    localparam logic [BYTE_W-1:0] HDR_LIT_MAX = 8'h7F;  // 128 literals
    localparam logic [BYTE_W-1:0] HDR_RUN_MAX = 8'h81;  // run of 128
    localparam logic [BYTE_W-1:0] HDR_RUN_MIN = 8'hFF;  // run of 2

    localparam logic [PLANE_PIXELS_W-1:0] PLANE_FULL_RANGE = 25'd16777216;
    localparam logic [PLANE_PIXELS_W-1:0] PLANE_ALL_ONES   = 25'h1FFFFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  steady = 1'b0;
    int                    errors;
    int                    pending;
    int                    idle_cycles = 0;

    pbd_byte_if                                   coded_ch ();
    pbd_pixel_if #(.PIXEL_INDEX_BITS(PIX_BITS))   decoded_ch ();

    packbits_plane_decoder #(.PIXEL_INDEX_BITS(PIX_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coded   (coded_ch),
        .decoded (decoded_ch)
    );

    pbd_decode_checker #(.PIXEL_INDEX_BITS(PIX_BITS)) decode_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .coded   (coded_ch),
        .decoded (decoded_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic restart);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            coded_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coded_ch.valid       <= 1'b1;
        coded_ch.data_byte   <= value;
        coded_ch.start_plane <= restart;
        do
            @(posedge clk);
        while (!coded_ch.ready);
    endtask

    // drop valid, drain every expected result, then give the block time to go idle
    task automatic settle();
        coded_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [PLANE_PIXELS_W-1:0] plane,
                              input logic [CHANNEL_W-1:0] lane);
        settle();
        write_reg(ADDR_PLANE, {7'($urandom), plane});
        write_reg(ADDR_CHANNEL, {30'($urandom), lane});
    endtask

    task automatic run_phase(input logic [PLANE_PIXELS_W-1:0] plane,
                             input logic [CHANNEL_W-1:0] lane, input logic quiet);
        int   sent;
        int   r;
        int   cnt;
        logic fresh;
        set_config(plane, lane);
        steady = quiet;
        sent   = 0;
        fresh  = 1'b1;
        while (sent < PHASE_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                cnt = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 7);
                send_byte(BYTE_W'(cnt), fresh);
                fresh = 1'b0;
                for (int i = 0; i <= cnt; i++)
                    send_byte(BYTE_W'($urandom), 1'b0);
                sent += cnt + 2;
            end
            else if (r < 85)
            begin
                send_byte(BYTE_W'($urandom_range(129, 255)), fresh);
                fresh = 1'b0;
                send_byte(BYTE_W'($urandom), 1'b0);
                sent += 2;
            end
            else if (r < 90)
            begin
                send_byte(HDR_SKIP, fresh);
                fresh = 1'b0;
            end
            else if (r < 95)
            begin
                // stray byte, possibly breaking a packet with a restart
                send_byte(BYTE_W'($urandom), 1'($urandom));
                sent++;
            end
            else
                fresh = 1'b1;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        decoded_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int gap;
            gap = steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                decoded_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            decoded_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (coded_ch.valid && coded_ch.ready)
                || (decoded_ch.valid && decoded_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        coded_ch.valid       <= 1'b0;
        coded_ch.data_byte   <= '0;
        coded_ch.start_plane <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: one-pixel plane, lane 0
        send_byte(8'h00, 1'b1);
        send_byte(8'h77, 1'b0);
        send_byte(8'h42, 1'b0);

        set_config(25'd6, 2'd3);
        send_byte(8'h02, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(HDR_SKIP, 1'b0);
        send_byte(HDR_RUN_MIN, 1'b0);
        send_byte(8'h5A, 1'b0);
        // longest run, clipped at the plane end
        send_byte(HDR_RUN_MAX, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h12, 1'b0);
        // odd run, single pixel in the last transaction
        send_byte(8'hFE, 1'b1);
        send_byte(8'hC3, 1'b0);
        // longest literal header, broken off by a restart
        send_byte(HDR_LIT_MAX, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        // run that fills the plane exactly
        send_byte(8'hFB, 1'b1);
        send_byte(8'h99, 1'b0);

        // empty plane
        set_config(25'd0, 2'd1);
        send_byte(8'h10, 1'b1);
        send_byte(8'hFF, 1'b0);

        run_phase(PLANE_ALL_ONES, 2'd2, 1'b1);
        run_phase(25'($urandom_range(1, 40)), 2'($urandom), 1'b0);
        run_phase(PLANE_FULL_RANGE, 2'd0, 1'b0);
        run_phase(25'($urandom_range(1, 8)), 2'd3, 1'b0);
        run_phase(25'($urandom_range(20, 200)), 2'd1, 1'b0);

        settle();
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
